>>> hdl/wth_pkg.sv
package wth_pkg;

  localparam int BYTE_W    = 8;
  localparam int HASH_W    = 32;
  localparam int LEN_W     = 7;
  localparam int FIELDS_W  = 3 * HASH_W + LEN_W;
  localparam int DATA_W    = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W     = DATA_W - FIELDS_W;
  localparam int DIV_CNT_W = $clog2(HASH_W);

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;

  // Word separators: space , . ' ! ? - _ # : ; ( ) { } [ ] < > newline tab
  function automatic logic is_delim(input logic [BYTE_W-1:0] b);
    logic d;
    case (b) inside
      8'h20, 8'h2c, 8'h2e, 8'h27, 8'h21, 8'h3f, 8'h2d, 8'h5f, 8'h23, 8'h3a, 8'h3b,
      8'h28, 8'h29, 8'h7b, 8'h7d, 8'h5b, 8'h5d, 8'h3c, 8'h3e, 8'h0a, 8'h09: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

  // hash * 16777620 + sign-extended lowercased byte; 16777620 = 2^24 + 2^8 + 2^7 + 2^4 + 2^2
  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] lc;
    logic [HASH_W-1:0] add;
    lc = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      lc = b + 8'h20;
    end
    add = {{(HASH_W - BYTE_W){lc[BYTE_W-1]}}, lc};
    return (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 2) + add;
  endfunction

endpackage

>>> hdl/word_tokenizer_hasher.sv
// Word tokenizer and hasher. Text comes in one byte per beat on s_*, s_tlast marking end of
// text (which flushes a pending word and restarts word numbering). Words are split at space,
// newline, tab and , . ' ! ? - _ # : ; ( ) { } [ ] < >; letters are lowercased and hashed as
// hash*16777620 + byte (bytes above 127 sign-extended). Each finished word gives one beat on
// m_* with its hash, bucket index ((hash+bucket_count) mod 2^32) mod bucket_count, length and
// word number; a word reaching WORD_LIMIT bytes gives one too-long beat (m_tuser high, fields
// zero but the word number) and the rest of it is skipped. A byte that ends a word stalls the
// input: the bucket index comes from a bit-serial remainder unit, one bit per cycle over all
// 32 hash bits, and the block takes no byte until the result is in the output register. A
// too-long result or a zero bucket_count skips the remainder unit. The user must write
// bucket_count on cfg_* only while idle; the block itself does not enforce this.
module word_tokenizer_hasher #(
  parameter int WORD_LIMIT = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [wth_pkg::BYTE_W-1:0]  s_tdata,   // text_byte
  input  logic                        s_tlast,   // end_of_text
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // word_hash[31:0], bucket_index[63:32], word_length[70:64], word_number[102:71], zero pad
  output logic [wth_pkg::DATA_W-1:0]  m_tdata,
  output logic                        m_tuser,   // status
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wth_pkg::HASH_W-1:0]  cfg_data   // bucket_count
);
  import wth_pkg::*;

  localparam int              CNT_W   = $clog2(WORD_LIMIT);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WORD_LIMIT - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [HASH_W-1:0] bucket_count;
  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] running_hash_next;
  logic [CNT_W-1:0]  letters;
  logic [CNT_W-1:0]  letters_next;
  logic              skipping;
  logic              skipping_next;
  logic [HASH_W-1:0] words_emitted;
  logic [HASH_W-1:0] words_emitted_next;

  logic              pend_status;
  logic [HASH_W-1:0] pend_hash;
  logic [HASH_W-1:0] pend_idx;
  logic [LEN_W-1:0]  pend_len;
  logic [HASH_W-1:0] pend_num;

  logic              accept;
  logic              emit;
  logic              emit_long;
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [HASH_W-1:0] div_rem;
  logic              out_free;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign div_start = accept && emit && (bucket_count != '0);

  always_comb begin
    running_hash_next  = running_hash;
    letters_next       = letters;
    skipping_next      = skipping;
    words_emitted_next = words_emitted;
    emit               = 1'b0;
    emit_long          = 1'b0;
    if (accept) begin
      if (s_tlast) begin
        emit               = (letters != '0) && !skipping;
        running_hash_next  = '0;
        letters_next       = '0;
        skipping_next      = 1'b0;
        words_emitted_next = '0;
      end else if (is_delim(s_tdata)) begin
        if (skipping) begin
          running_hash_next = '0;
          letters_next      = '0;
          skipping_next     = 1'b0;
        end else if (letters != '0) begin
          emit               = 1'b1;
          running_hash_next  = '0;
          letters_next       = '0;
          words_emitted_next = words_emitted + 1'b1;
        end
      end else if (!skipping) begin
        if (letters >= CNT_MAX) begin
          emit_long         = 1'b1;
          running_hash_next = '0;
          letters_next      = '0;
          skipping_next     = 1'b1;
        end else begin
          running_hash_next = hash_step(running_hash, s_tdata);
          letters_next      = letters + 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (div_start) begin
          state_next = ST_DIV;
        end else if (accept && (emit || emit_long)) begin
          state_next = ST_LOAD;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      bucket_count  <= HASH_W'(32);
      running_hash  <= '0;
      letters       <= '0;
      skipping      <= 1'b0;
      words_emitted <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state         <= state_next;
      running_hash  <= running_hash_next;
      letters       <= letters_next;
      skipping      <= skipping_next;
      words_emitted <= words_emitted_next;
      if (cfg_valid && cfg_ready) begin
        bucket_count <= cfg_data;
      end
      if (state == ST_LOAD && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      pend_status <= STATUS_OK;
      pend_hash   <= running_hash;
      pend_len    <= LEN_W'(letters);
      pend_num    <= words_emitted;
      pend_idx    <= '0;
    end else if (accept && emit_long) begin
      pend_status <= STATUS_TOO_LONG;
      pend_hash   <= '0;
      pend_len    <= '0;
      pend_num    <= words_emitted;
      pend_idx    <= '0;
    end else if (div_done) begin
      pend_idx <= div_rem;
    end
    if (state == ST_LOAD && out_free) begin
      m_tdata <= {{PAD_W{1'b0}}, pend_num, pend_len, pend_idx, pend_hash};
      m_tuser <= pend_status;
    end
  end

  wth_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (running_hash + bucket_count),
    .divisor   (bucket_count),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

`ifndef SYNTH
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    (div_busy || div_done) |-> state == ST_DIV)
    else $error("remainder unit active outside its state");

  a_skip_no_count: assert property (@(posedge clk) disable iff (rst)
    skipping |-> letters == '0 && running_hash == '0)
    else $error("skipped word kept hash or count");

  a_long_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_TOO_LONG) |-> m_tdata[2*HASH_W+LEN_W-1:0] == '0)
    else $error("too-long result carries word data");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_OK && bucket_count != '0) |->
      m_tdata[2*HASH_W-1:HASH_W] < bucket_count)
    else $error("bucket index out of range");
`endif

endmodule

>>> hdl/wth_mod_unit.sv
module wth_mod_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wth_pkg::HASH_W-1:0]  dividend,
  input  logic [wth_pkg::HASH_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [wth_pkg::HASH_W-1:0]  remainder
);
  import wth_pkg::*;

  logic [HASH_W-1:0]    rem;
  logic [HASH_W-1:0]    dvd;
  logic [HASH_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [HASH_W:0]      trial;
  logic [HASH_W:0]      diff;
  logic [HASH_W-1:0]    rem_next;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial    = {rem, dvd[HASH_W-1]};
    diff     = trial - {1'b0, dvs};
    rem_next = diff[HASH_W] ? trial[HASH_W-1:0] : diff[HASH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(HASH_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd << 1;
    end
  end

  assign remainder = rem;

endmodule
